FILE: src/crse_pkg.sv
package crse_pkg;

    // Fixed-point format of coordinates and of the normalized parameter.
    localparam int COORD_FRAC_BITS = 16;
    localparam int SN_FRAC         = 16;
    localparam int SN_W            = SN_FRAC + 1;
    localparam int SN_SHIFT        = 2 * COORD_FRAC_BITS - SN_FRAC;

    // Datapath widths.
    localparam int PT_W    = 32;
    localparam int COEF_W  = 36;
    localparam int CSUM_W  = COEF_W + 1;
    localparam int ACC_W   = 42;
    localparam int OUT_W   = 40;
    localparam int DIFF_W  = PT_W + 1;
    localparam int PROD_W  = 2 * PT_W;
    localparam int CMD_W   = 2;
    localparam int PIDX_W  = 2;
    localparam int NPTS    = 4;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POS    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DERIV1 = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DERIV2 = 2'd3;

    // Horner step index plus command code equals this on the last step.
    localparam logic [CMD_W-1:0] STEP_END = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE = 1'b1;
    localparam logic [PT_W-1:0]      INV_RESET   = 32'h0001_0000;

    // One in Q1.SN_FRAC and one in the exact product format.
    localparam logic [SN_W-1:0]   SN_ONE   = SN_W'(1) << SN_FRAC;
    localparam logic [PROD_W-1:0] PROD_ONE = PROD_W'(1) << (2 * COORD_FRAC_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COEF,
        S_NORM,
        S_STEP
    } t_state;

    // Control from the sequencer to every axis lane.
    typedef struct packed {
        logic                load;
        logic [PIDX_W-1:0]   pidx;
        logic                coef_en;
        logic                step_en;
        logic                first;
        logic                sel_d;
        logic [CMD_W-1:0]    cmd;
    } t_lane_ctl;

endpackage

FILE: src/crse_in_if.sv
interface crse_in_if;
    import crse_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic [PIDX_W-1:0]         point_index;
    logic signed [PT_W-1:0]    coord_x;
    logic signed [PT_W-1:0]    coord_y;
    logic signed [PT_W-1:0]    coord_z;
    logic signed [PT_W-1:0]    param_s;

    modport source (
        output valid, cmd, point_index, coord_x, coord_y, coord_z, param_s,
        input  ready
    );

    modport sink (
        input  valid, cmd, point_index, coord_x, coord_y, coord_z, param_s,
        output ready
    );
endinterface

FILE: src/crse_out_if.sv
interface crse_out_if;
    import crse_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [OUT_W-1:0]   out_x;
    logic signed [OUT_W-1:0]   out_y;
    logic signed [OUT_W-1:0]   out_z;
    logic                      in_bounds;

    modport source (
        output valid, out_x, out_y, out_z, in_bounds,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, in_bounds,
        output ready
    );
endinterface

FILE: src/catmull_rom_segment_eval.sv
// Channel  Dir  Handshake        Word contents
// -------  ---  ---------------  ---------------------------------------------
// i_in     in   valid / ready    cmd, point_index, coord_x/y/z, param_s
// o_out    out  valid / ready    out_x, out_y, out_z, in_bounds
// i_cfg    in   write enable     i_cfg_idx selects start or inverse length
//
// A load word writes the point when it is accepted, and the coefficients are
// rebuilt in the next cycle. An evaluate word first forms the normalized
// parameter through the 32x32 multiplier, then runs one Horner step per cycle
// on the shared per-axis multiply and add (three for position, two for first
// derivative, one for second derivative).
// Reset is synchronous and active low; it clears the points, coefficients,
// start value and sequencer, and sets the inverse length to one. The output
// register holds a finished word while the next input word is already
// accepted; the last Horner step waits only if that register is still full.
module catmull_rom_segment_eval (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [crse_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [crse_pkg::PT_W-1:0]         i_cfg_data,
    crse_in_if.sink                           i_in,
    crse_out_if.source                        o_out
);
    import crse_pkg::*;

    // Configuration registers.
    logic signed [PT_W-1:0] r_start;
    logic [PT_W-1:0]        r_inverse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_inverse <= INV_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START:   r_start   <= $signed(i_cfg_data);
                CFG_INVERSE: r_inverse <= i_cfg_data;
                default:     r_inverse <= r_inverse;
            endcase
        end
    end

    // Sequencer state.
    t_state             r_state, n_state;
    logic [CMD_W-1:0]   r_cmd;
    logic [CMD_W-1:0]   r_step;
    logic               r_out_valid;

    logic               w_accept;
    logic               w_last;
    logic               w_can_finish;
    logic               w_in_ready;
    logic               w_norm_load;
    logic               w_norm_calc;
    logic               w_out_load;
    t_lane_ctl          w_ctl;

    assign w_accept     = i_in.valid && w_in_ready;
    assign w_last       = (r_step == (STEP_END - r_cmd));
    assign w_can_finish = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = (i_in.cmd == CMD_LOAD) ? S_COEF : S_NORM;
                end
            end
            S_COEF: n_state = S_IDLE;
            S_NORM: n_state = S_STEP;
            S_STEP: begin
                if (w_last && w_can_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready    = 1'b0;
        w_norm_load   = 1'b0;
        w_norm_calc   = 1'b0;
        w_out_load    = 1'b0;
        w_ctl.load    = 1'b0;
        w_ctl.pidx    = i_in.point_index;
        w_ctl.coef_en = 1'b0;
        w_ctl.step_en = 1'b0;
        w_ctl.first   = (r_step == '0);
        // Only position reaches the third step, whose base is the constant
        // term; every other later step adds the linear coefficient.
        w_ctl.sel_d   = (r_step == STEP_END - CMD_POS);
        w_ctl.cmd     = r_cmd;
        case (r_state)
            S_IDLE: begin
                w_in_ready  = 1'b1;
                w_ctl.load  = i_in.valid && (i_in.cmd == CMD_LOAD);
                w_norm_load = i_in.valid && (i_in.cmd != CMD_LOAD);
            end
            S_COEF: w_ctl.coef_en = 1'b1;
            S_NORM: w_norm_calc = 1'b1;
            S_STEP: begin
                w_ctl.step_en = !w_last || w_can_finish;
                w_out_load    = w_last && w_can_finish;
            end
            default: w_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= CMD_LOAD;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cmd <= i_in.cmd;
            end
            if (w_norm_calc) begin
                r_step <= '0;
            end else if (w_ctl.step_en) begin
                r_step <= r_step + CMD_W'(1);
            end
        end
    end

    assign i_in.ready = w_in_ready;

    // Normalized parameter.
    logic [SN_W-1:0] w_sn;
    logic            w_inb;

    crse_norm u_norm (
        .i_clk     (i_clk),
        .i_load    (w_norm_load),
        .i_calc    (w_norm_calc),
        .i_param   (i_in.param_s),
        .i_start   (r_start),
        .i_inverse (r_inverse),
        .o_sn      (w_sn),
        .o_inb     (w_inb)
    );

    // One lane per axis, all driven by the same sequencer.
    logic signed [ACC_W-1:0] w_next_x, w_next_y, w_next_z;

    crse_lane u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_coord (i_in.coord_x),
        .i_sn    (w_sn),
        .o_next  (w_next_x)
    );

    crse_lane u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_coord (i_in.coord_y),
        .i_sn    (w_sn),
        .o_next  (w_next_y)
    );

    crse_lane u_lane_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_coord (i_in.coord_z),
        .i_sn    (w_sn),
        .o_next  (w_next_z)
    );

    // Merge stage: the last Horner step of all three lanes and the bounds
    // flag are gathered into one output word.
    logic signed [OUT_W-1:0] r_out_x, r_out_y, r_out_z;
    logic                    r_out_inb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_x   <= w_next_x[OUT_W-1:0];
            r_out_y   <= w_next_y[OUT_W-1:0];
            r_out_z   <= w_next_z[OUT_W-1:0];
            r_out_inb <= w_inb;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_x     = r_out_x;
    assign o_out.out_y     = r_out_y;
    assign o_out.out_z     = r_out_z;
    assign o_out.in_bounds = r_out_inb;

    // The output register is never overwritten while it holds an untaken word.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || o_out.ready))
        else $error("output word overwritten before it was taken");

    // The Horner step count never runs past the last step of the command.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (({1'b0, r_step} + {1'b0, r_cmd}) <= {1'b0, STEP_END}))
        else $error("Horner step beyond the last step");

    // The clamped parameter never exceeds one.
    a_sn_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (w_sn <= SN_ONE))
        else $error("normalized parameter above one");

    // A load word is always followed by the coefficient rebuild.
    a_load_coef: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.cmd == CMD_LOAD)) |=> (r_state == S_COEF))
        else $error("coefficients not rebuilt after a load");
endmodule

FILE: src/crse_norm.sv
module crse_norm (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  logic                            i_calc,
    input  logic signed [crse_pkg::PT_W-1:0] i_param,
    input  logic signed [crse_pkg::PT_W-1:0] i_start,
    input  logic [crse_pkg::PT_W-1:0]        i_inverse,
    output logic [crse_pkg::SN_W-1:0]        o_sn,
    output logic                             o_inb
);
    import crse_pkg::*;

    logic signed [DIFF_W-1:0] r_diff;
    logic [SN_W-1:0]          r_sn;
    logic                     r_inb;
    logic [PROD_W-1:0]        w_prod;
    logic [SN_W-1:0]          n_sn;
    logic                     n_inb;

    // The difference is non-negative whenever the product is used, so its
    // low bits are the full magnitude.
    assign w_prod = PROD_W'(r_diff[PT_W-1:0]) * PROD_W'(i_inverse);

    always_comb begin
        if (r_diff[DIFF_W-1]) begin
            n_sn  = '0;
            n_inb = 1'b0;
        end else if (w_prod > PROD_ONE) begin
            n_sn  = SN_ONE;
            n_inb = 1'b0;
        end else begin
            n_sn  = w_prod[SN_SHIFT +: SN_W];
            n_inb = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_diff <= DIFF_W'(i_param) - DIFF_W'(i_start);
        end
        if (i_calc) begin
            r_sn  <= n_sn;
            r_inb <= n_inb;
        end
    end

    assign o_sn  = r_sn;
    assign o_inb = r_inb;
endmodule

FILE: src/crse_lane.sv
module crse_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  crse_pkg::t_lane_ctl               i_ctl,
    input  logic signed [crse_pkg::PT_W-1:0]  i_coord,
    input  logic [crse_pkg::SN_W-1:0]         i_sn,
    output logic signed [crse_pkg::ACC_W-1:0] o_next
);
    import crse_pkg::*;

    logic signed [PT_W-1:0]         r_pts [NPTS];
    logic signed [COEF_W-1:0]       r_a, r_b, r_c, r_d;
    logic signed [ACC_W-1:0]        r_acc;

    logic signed [CSUM_W-1:0]       w_e0, w_e1, w_e2, w_e3;
    logic signed [CSUM_W-1:0]       w_sum_a, w_sum_b, w_sum_c;
    logic signed [ACC_W-1:0]        w_a, w_a3, w_a6, w_b, w_b2, w_c, w_d;
    logic signed [ACC_W-1:0]        w_mult, w_base;
    logic signed [ACC_W+SN_W:0]     w_prod;
    logic signed [ACC_W-1:0]        w_term;

    // Coefficients of the segment between the two inner points.
    assign w_e0 = CSUM_W'(r_pts[0]);
    assign w_e1 = CSUM_W'(r_pts[1]);
    assign w_e2 = CSUM_W'(r_pts[2]);
    assign w_e3 = CSUM_W'(r_pts[3]);

    assign w_sum_a = -w_e0 + (w_e1 <<< 1) + w_e1 - (w_e2 <<< 1) - w_e2 + w_e3;
    assign w_sum_b = (w_e0 <<< 1) - (w_e1 <<< 2) - w_e1 + (w_e2 <<< 2) - w_e3;
    assign w_sum_c = w_e2 - w_e0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NPTS; i++) begin
                r_pts[i] <= '0;
            end
            r_a <= '0;
            r_b <= '0;
            r_c <= '0;
            r_d <= '0;
        end else begin
            if (i_ctl.load) begin
                r_pts[i_ctl.pidx] <= i_coord;
            end
            if (i_ctl.coef_en) begin
                // Dropping the low bit halves toward minus infinity.
                r_a <= w_sum_a[CSUM_W-1:1];
                r_b <= w_sum_b[CSUM_W-1:1];
                r_c <= w_sum_c[CSUM_W-1:1];
                r_d <= COEF_W'(r_pts[1]);
            end
        end
    end

    // One Horner step: base + floor(mult * sn).
    assign w_a  = ACC_W'(r_a);
    assign w_a3 = w_a + (w_a <<< 1);
    assign w_a6 = w_a3 <<< 1;
    assign w_b  = ACC_W'(r_b);
    assign w_b2 = w_b <<< 1;
    assign w_c  = ACC_W'(r_c);
    assign w_d  = ACC_W'(r_d);

    always_comb begin
        if (i_ctl.first) begin
            case (i_ctl.cmd)
                CMD_POS: begin
                    w_mult = w_a;
                    w_base = w_b;
                end
                CMD_DERIV1: begin
                    w_mult = w_a3;
                    w_base = w_b2;
                end
                default: begin
                    w_mult = w_a6;
                    w_base = w_b2;
                end
            endcase
        end else begin
            w_mult = r_acc;
            w_base = i_ctl.sel_d ? w_d : w_c;
        end
    end

    assign w_prod = w_mult * $signed({1'b0, i_sn});
    assign w_term = $signed(w_prod[SN_FRAC +: ACC_W]);
    assign o_next = w_base + w_term;

    always_ff @(posedge i_clk) begin
        if (i_ctl.step_en) begin
            r_acc <= o_next;
        end
    end
endmodule
